@@ design/nntt_pkg.sv @@
// Package for the track table: sizes, widths and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nntt_pkg;
  localparam int MAX_TRACKS_DEF = 32;
  localparam int HISTORY_DEPTH_DEF = 10;
  localparam int POS_W = 24;
  localparam int DISP_W = 25;
  localparam int AGE_W = 4;
  localparam int CNT_W = 6;
  localparam int DROP_W = 16;
  localparam logic [AGE_W-1:0] AGE_MAX = 4'd15;
  localparam logic [DROP_W-1:0] DROP_MAX = 16'hFFFF;
  localparam logic [1:0] REG_GATE = 2'd0;
  localparam logic [1:0] REG_MOVE = 2'd1;
  localparam logic [1:0] REG_MISS = 2'd2;
endpackage
`default_nettype wire

@@ design/nearest_neighbor_track_table.sv @@
// Track table top level: config registers, history memories, sequencer.
// Depends on nntt_pkg.
// Detection compares the input with each stored track, shifts the history of each gated
// track and fills a history to open a track. Frame end compacts the surviving tracks, emits
// each moving track and then a closing record (both can wait on output stalls), then ages
// the tracks. One transaction at a time; reset clears control state, counters and config
// registers; memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module nearest_neighbor_track_table
  import nntt_pkg::*;
#(
  parameter int MAX_TRACKS = MAX_TRACKS_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              req_type,
  input  wire logic signed [POS_W-1:0] det_x,
  input  wire logic signed [POS_W-1:0] det_y,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   is_track,
  output logic signed [POS_W-1:0]  track_x,
  output logic signed [POS_W-1:0]  track_y,
  output logic signed [DISP_W-1:0] disp_x,
  output logic signed [DISP_W-1:0] disp_y,
  output logic [CNT_W-1:0]       track_count,
  output logic [DROP_W-1:0]      dropped_count,
  output logic                   last
);
  localparam int TW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int DEPTH = MAX_TRACKS * HISTORY_DEPTH;
  localparam int AW = $clog2(DEPTH);
  localparam logic [HW-1:0] H_LAST = HW'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] MAXT = CNT_W'(MAX_TRACKS);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001, S_DRD   = 16'h0002, S_DCMP  = 16'h0004,
    S_SHRD  = 16'h0008, S_SHWR  = 16'h0010, S_DNEXT = 16'h0020,
    S_FILL  = 16'h0040, S_CRD   = 16'h0080, S_CCPR  = 16'h0100,
    S_CCPW  = 16'h0200, S_ERD   = 16'h0400, S_ERD2  = 16'h0800,
    S_ECMP  = 16'h1000, S_EWAIT = 16'h2000, S_CLOSE = 16'h4000,
    S_AGE   = 16'h8000
  } state_t;

  state_t state;
  logic [15:0] gate_dist, move_threshold;
  logic [AGE_W-1:0] miss_limit;
  logic [CNT_W-1:0] count_of_tracks, dst;
  logic [DROP_W-1:0] drop_counter;
  logic [CNT_W-1:0] t;
  logic [TW-1:0] ti;
  logic [HW-1:0] k;
  logic matched;
  logic signed [POS_W-1:0] cx, cy, hold_x, hold_y, newx, newy;

  logic signed [POS_W-1:0] mem_x [DEPTH];
  logic signed [POS_W-1:0] mem_y [DEPTH];
  logic [AGE_W-1:0] age [MAX_TRACKS];
  logic [AW-1:0] raddr, waddr;
  logic we;
  logic signed [POS_W-1:0] wx, wy, rx, ry;

  assign ti = t[TW-1:0];

  function automatic logic [AW-1:0] addr_of(logic [CNT_W-1:0] tr, logic [HW-1:0] s);
    return AW'(tr * HISTORY_DEPTH) + AW'(s);
  endfunction

  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[waddr] <= wx;
      mem_y[waddr] <= wy;
    end
    rx <= mem_x[raddr];
    ry <= mem_y[raddr];
  end

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[3:2])
      REG_GATE: prdata = {16'd0, gate_dist};
      REG_MOVE: prdata = {16'd0, move_threshold};
      REG_MISS: prdata = {28'd0, miss_limit};
      default:  prdata = 32'd0;
    endcase
  end

  // squared distance stage, registered product before the sum
  logic signed [POS_W:0] ddx, ddy;
  logic [2*POS_W+1:0] sqx, sqy;
  logic [31:0] gate2;
  assign ddx = (POS_W+1)'(cx) - (POS_W+1)'(rx);
  assign ddy = (POS_W+1)'(cy) - (POS_W+1)'(ry);
  logic [POS_W:0] ax, ay;
  assign ax = ddx[POS_W] ? (POS_W+1)'(-ddx) : ddx;
  assign ay = ddy[POS_W] ? (POS_W+1)'(-ddy) : ddy;

  logic signed [DISP_W-1:0] ex, ey, nxe;
  logic signed [POS_W-1:0] nwx, nwy;
  logic moving, out_load;

  assign in_stall = (state != S_IDLE);
  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign moving = (ex > $signed({9'd0, move_threshold})) ||
                  (ey > $signed({9'd0, move_threshold}));
  assign out_load = out_free && ((state == S_EWAIT && moving) || state == S_CLOSE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      gate_dist <= 16'd512;
      move_threshold <= 16'd230;
      miss_limit <= 4'd9;
      count_of_tracks <= '0;
      drop_counter <= '0;
      out_valid <= 1'b0;
      we <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (paddr[3:2])
          REG_GATE: gate_dist <= pwdata[15:0];
          REG_MOVE: move_threshold <= pwdata[15:0];
          REG_MISS: miss_limit <= pwdata[3:0];
          default: ;
        endcase
      end
      out_valid <= out_load || (out_valid && out_stall);
      we <= (state == S_SHWR) || (state == S_FILL) || (state == S_CCPW);
      unique case (state)
        S_IDLE: if (in_valid) begin
          cx <= det_x; cy <= det_y; t <= '0; matched <= 1'b0;
          dst <= '0;
          gate2 <= gate_dist * gate_dist;
          if (!req_type) begin
            if (count_of_tracks == 0) begin k <= '0; state <= S_FILL; end
            else begin raddr <= addr_of('0, '0); state <= S_DRD; end
          end else if (count_of_tracks == 0) state <= S_CLOSE;
          else state <= S_CRD;
        end
        S_DRD: state <= S_DCMP;
        S_DCMP: begin
          sqx <= ax * ax; sqy <= ay * ay;
          state <= S_DNEXT;
        end
        S_DNEXT: begin
          if ((sqx + sqy) < {18'd0, gate2}) begin
            matched <= 1'b1; age[ti] <= '0; k <= H_LAST;
            raddr <= addr_of(t, H_LAST - 1'b1);
            state <= S_SHRD;
          end else if (CNT_W'(t) + 1'b1 < count_of_tracks) begin
            t <= t + 1'b1; raddr <= addr_of(t + 1'b1, '0); state <= S_DRD;
          end else if (matched) state <= S_IDLE;
          else if (count_of_tracks < MAXT) begin k <= '0; state <= S_FILL; end
          else begin
            if (drop_counter != DROP_MAX) drop_counter <= drop_counter + 1'b1;
            state <= S_IDLE;
          end
        end
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          waddr <= addr_of(t, k);
          if (k == 0) begin
            wx <= cx; wy <= cy;
            if (CNT_W'(t) + 1'b1 < count_of_tracks) begin
              t <= t + 1'b1; raddr <= addr_of(t + 1'b1, '0); state <= S_DRD;
            end else state <= S_IDLE;
          end else begin
            wx <= rx; wy <= ry; k <= k - 1'b1;
            if (k != 1) raddr <= addr_of(t, k - 2'd2);
            state <= (k == 1) ? S_SHWR : S_SHRD;
          end
        end
        S_FILL: begin
          waddr <= addr_of(count_of_tracks, k);
          wx <= cx; wy <= cy;
          if (k == H_LAST) begin
            age[TW'(count_of_tracks)] <= '0;
            count_of_tracks <= count_of_tracks + 1'b1;
            state <= S_IDLE;
          end else k <= k + 1'b1;
        end
        S_CRD: begin
          if (CNT_W'(t) >= count_of_tracks) begin
            count_of_tracks <= dst; t <= '0;
            if (dst == 0) state <= S_CLOSE;
            else begin raddr <= addr_of('0, '0); state <= S_ERD; end
          end else if (age[ti] > miss_limit) t <= t + 1'b1;
          else if (dst == CNT_W'(t)) begin dst <= dst + 1'b1; t <= t + 1'b1; end
          else begin
            age[TW'(dst)] <= age[ti]; k <= '0;
            raddr <= addr_of(t, '0); state <= S_CCPR;
          end
        end
        S_CCPR: state <= S_CCPW;
        S_CCPW: begin
          waddr <= addr_of(dst, k); wx <= rx; wy <= ry;
          if (k == H_LAST) begin
            dst <= dst + 1'b1; t <= t + 1'b1; state <= S_CRD;
          end else begin
            k <= k + 1'b1; raddr <= addr_of(t, k + 1'b1); state <= S_CCPR;
          end
        end
        S_ERD: begin raddr <= addr_of(t, H_LAST); state <= S_ERD2; end
        S_ERD2: begin state <= S_ECMP; end
        S_ECMP: begin nwx <= newx; nwy <= newy; state <= S_EWAIT; end
        S_EWAIT: if (out_free) begin
          if (moving) begin
            is_track <= 1'b1; last <= 1'b0;
            track_x <= nwx; track_y <= nwy; disp_x <= ex; disp_y <= ey;
            track_count <= '0; dropped_count <= '0;
          end
          if (CNT_W'(t) + 1'b1 < count_of_tracks) begin
            t <= t + 1'b1; raddr <= addr_of(t + 1'b1, '0); state <= S_ERD;
          end else state <= S_CLOSE;
        end
        S_CLOSE: if (out_free) begin
          is_track <= 1'b0; last <= 1'b1;
          track_x <= '0; track_y <= '0; disp_x <= '0; disp_y <= '0;
          track_count <= count_of_tracks; dropped_count <= drop_counter;
          t <= '0; state <= S_AGE;
        end
        S_AGE: begin
          if (CNT_W'(t) < count_of_tracks) begin
            if (age[ti] != AGE_MAX) age[ti] <= age[ti] + 1'b1;
            t <= t + 1'b1;
          end
          if (CNT_W'(t) + 1'b1 >= count_of_tracks) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
  // newest arrives one read earlier: hold it across the oldest read
  always_ff @(posedge clk) if (state == S_ERD2) begin hold_x <= rx; hold_y <= ry; end
  assign newx = hold_x;
  assign newy = hold_y;
  assign nxe = '0;
  assign ex = DISP_W'(nwx) - DISP_W'(rx) + nxe;
  assign ey = DISP_W'(nwy) - DISP_W'(ry);

  // in S_EWAIT rx holds oldest, nwx holds newest

  assert property (@(posedge clk) disable iff (rst) out_valid && out_stall |=> out_valid);
  assert property (@(posedge clk) disable iff (rst) count_of_tracks <= MAXT)
    else $error("track count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL && k == H_LAST) |=> count_of_tracks == $past(count_of_tracks) + 1'b1)
    else $error("fill did not open a track");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable({is_track, track_x, track_y, disp_x, disp_y,
                                        track_count, dropped_count, last}))
    else $error("stalled record changed");
endmodule
`default_nettype wire
